// ===== src/xrs_pkg.sv =====
// shared types, opcodes and constants of the xoshiro random source
package xrs_pkg;

   // request opcodes
   localparam logic [3:0] OP_DRAW64      = 4'd0;
   localparam logic [3:0] OP_DRAW32      = 4'd1;
   localparam logic [3:0] OP_DRAW16      = 4'd2;
   localparam logic [3:0] OP_DRAW8       = 4'd3;
   localparam logic [3:0] OP_UNIT_SINGLE = 4'd4;
   localparam logic [3:0] OP_UNIT_DOUBLE = 4'd5;
   localparam logic [3:0] OP_SEED        = 4'd6;
   localparam logic [3:0] OP_WRITE       = 4'd7;
   localparam logic [3:0] OP_READ        = 4'd8;

   // splitmix64 constants
   localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_ONE      = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_TWO      = 64'h94d0_49bb_1331_11eb;

   // fraction masks
   localparam logic [63:0] FRAC_SINGLE_MASK = 64'h0000_0000_007f_ffff;
   localparam logic [63:0] FRAC_DOUBLE_MASK = 64'h000f_ffff_ffff_ffff;

   // slices held by each pool after a refill
   localparam logic [1:0] SLICES_32 = 2'd2;
   localparam logic [2:0] SLICES_16 = 3'd4;
   localparam logic [3:0] SLICES_8  = 4'd8;

   // chained mixing rounds in a seed
   localparam int SEED_ROUNDS = 4;

   // operands handed to the shared multiplier
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } mul_req_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAW1,
      ST_DRAW2,
      ST_SLICE,
      ST_ADD,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_POST,
      ST_DONE
   } state_type;

endpackage

// ===== src/xoshiro_random_source_core.sv =====
// xoshiro256** generator: sequencer, state words, pools and result register
// read, write and unused codes go straight to the result; draw64 and unit double take a draw,
// slice ops take a slice from a filled pool or draw and refill first, seed runs its rounds
// each seed round makes two products, each three passes of the shared multiplier
// one request is handled at a time; a new one is taken while a result waits
// synchronous reset clears the sequencer, state words, pools and counts to zero
module xoshiro_random_source_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [63:0] req_word_in,
   input  logic [1:0]  req_word_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value
);
   import xrs_pkg::*;

   state_type   state_ff, state_in;
   logic [63:0] gw_ff [4];
   logic [63:0] gw_in [4];
   logic [63:0] p32_ff, p32_in, p16_ff, p16_in, p8_ff, p8_in;
   logic [1:0]  left32_ff, left32_in;
   logic [2:0]  left16_ff, left16_in;
   logic [3:0]  left8_ff, left8_in;
   logic [3:0]  op_ff, op_in;
   logic [63:0] seed_ff, seed_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mop_ff, mop_in;
   logic [63:0] res_ff, res_in;
   logic        mul_sel_ff, mul_sel_in;
   logic [1:0]  rnd_ff, rnd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;

   logic        slot_free;
   mul_req_type mul_req;
   logic [63:0] mul_prod;
   logic [63:0] mul_k;
   logic [63:0] draw_rot, draw_val;
   logic [63:0] n0, n1, n2, n3;
   logic [63:0] add_t, fin_w;

   // shared multiplier
   xrs_mul_unit u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   // output slot is free when empty or being taken
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // xoshiro256 state update
   always_comb begin
      n2 = gw_ff[2] ^ gw_ff[0];
      n3 = gw_ff[3] ^ gw_ff[1];
      n1 = gw_ff[1] ^ n2;
      n0 = gw_ff[0] ^ n3;
      n2 = n2 ^ {gw_ff[1][46:0], 17'b0};
      n3 = {n3[18:0], n3[63:19]};
   end

   // star-star scrambler second half: rotate by 7, times 9
   assign draw_rot = {acc_ff[56:0], acc_ff[63:57]};
   assign draw_val = draw_rot + {draw_rot[60:0], 3'b0};

   // splitmix helpers
   assign add_t = seed_ff + GOLDEN_GAMMA;
   assign fin_w = acc_ff ^ (acc_ff >> 31);
   assign mul_k = mul_sel_ff ? MIX_TWO : MIX_ONE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OP_DRAW64, OP_UNIT_DOUBLE: state_in = ST_DRAW1;
                  OP_DRAW32, OP_UNIT_SINGLE:
                     state_in = (left32_ff == '0) ? ST_DRAW1 : ST_SLICE;
                  OP_DRAW16: state_in = (left16_ff == '0) ? ST_DRAW1 : ST_SLICE;
                  OP_DRAW8:  state_in = (left8_ff == '0) ? ST_DRAW1 : ST_SLICE;
                  OP_SEED:   state_in = ST_ADD;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_DRAW1: state_in = ST_DRAW2;
         ST_DRAW2: begin
            case (op_ff)
               OP_DRAW32, OP_DRAW16, OP_DRAW8, OP_UNIT_SINGLE: state_in = ST_SLICE;
               default: state_in = ST_DONE;
            endcase
         end
         ST_SLICE: state_in = ST_DONE;
         ST_ADD:   state_in = ST_MUL0;
         ST_MUL0:  state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_POST;
         ST_POST: begin
            if (!mul_sel_ff) begin
               state_in = ST_MUL0;
            end else if (rnd_ff == 2'(SEED_ROUNDS - 1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: ready and multiplier operands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_req.a = mop_ff[31:0];
      mul_req.b = mul_k[31:0];
      case (state_ff)
         ST_MUL1: begin
            mul_req.a = mop_ff[31:0];
            mul_req.b = mul_k[63:32];
         end
         ST_MUL2: begin
            mul_req.a = mop_ff[63:32];
            mul_req.b = mul_k[31:0];
         end
         default: begin
            mul_req.a = mop_ff[31:0];
            mul_req.b = mul_k[31:0];
         end
      endcase
   end

   // datapath next values
   always_comb begin
      gw_in      = gw_ff;
      p32_in     = p32_ff;
      p16_in     = p16_ff;
      p8_in      = p8_ff;
      left32_in  = left32_ff;
      left16_in  = left16_ff;
      left8_in   = left8_ff;
      op_in      = op_ff;
      seed_in    = seed_ff;
      acc_in     = acc_ff;
      mop_in     = mop_ff;
      res_in     = res_ff;
      mul_sel_in = mul_sel_ff;
      rnd_in     = rnd_ff;
      case (state_ff)
         // take the request; write and read happen here
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_opcode;
               seed_in    = req_word_in;
               res_in     = '0;
               mul_sel_in = 1'b0;
               rnd_in     = '0;
               if (req_opcode == OP_WRITE) begin
                  gw_in[req_word_index] = req_word_in;
               end
               if (req_opcode == OP_READ) begin
                  res_in = gw_ff[req_word_index];
               end
            end
         end
         // times five on word one, advance the state
         ST_DRAW1: begin
            acc_in   = gw_ff[1] + {gw_ff[1][61:0], 2'b0};
            gw_in[0] = n0;
            gw_in[1] = n1;
            gw_in[2] = n2;
            gw_in[3] = n3;
         end
         // finished draw: result or pool refill
         ST_DRAW2: begin
            case (op_ff)
               OP_DRAW64:      res_in = draw_val;
               OP_UNIT_DOUBLE: res_in = draw_val & FRAC_DOUBLE_MASK;
               OP_DRAW32, OP_UNIT_SINGLE: begin
                  p32_in    = draw_val;
                  left32_in = SLICES_32;
               end
               OP_DRAW16: begin
                  p16_in    = draw_val;
                  left16_in = SLICES_16;
               end
               OP_DRAW8: begin
                  p8_in    = draw_val;
                  left8_in = SLICES_8;
               end
               default: ;
            endcase
         end
         // hand out the low slice of a pool
         ST_SLICE: begin
            case (op_ff)
               OP_DRAW32, OP_UNIT_SINGLE: begin
                  res_in    = (op_ff == OP_UNIT_SINGLE) ? (p32_ff & FRAC_SINGLE_MASK)
                                                        : {32'b0, p32_ff[31:0]};
                  p32_in    = p32_ff >> 32;
                  left32_in = left32_ff - 2'd1;
               end
               OP_DRAW16: begin
                  res_in    = {48'b0, p16_ff[15:0]};
                  p16_in    = p16_ff >> 16;
                  left16_in = left16_ff - 3'd1;
               end
               OP_DRAW8: begin
                  res_in   = {56'b0, p8_ff[7:0]};
                  p8_in    = p8_ff >> 8;
                  left8_in = left8_ff - 4'd1;
               end
               default: ;
            endcase
         end
         // seed round: add gamma and fold
         ST_ADD: mop_in = add_t ^ (add_t >> 30);
         // low by low product
         ST_MUL1: acc_in = mul_prod;
         // cross products into the upper half
         ST_MUL2, ST_MUL3: acc_in[63:32] = acc_ff[63:32] + mul_prod[31:0];
         // second fold, or end of round
         ST_POST: begin
            if (!mul_sel_ff) begin
               mop_in     = acc_ff ^ (acc_ff >> 27);
               mul_sel_in = 1'b1;
            end else begin
               gw_in[rnd_ff] = fin_w;
               seed_in       = fin_w;
               mul_sel_in    = 1'b0;
               rnd_in        = rnd_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_ff;
      end
   end

   // control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gw_ff        <= '{default: '0};
         p32_ff       <= '0;
         p16_ff       <= '0;
         p8_ff        <= '0;
         left32_ff    <= '0;
         left16_ff    <= '0;
         left8_ff     <= '0;
         mul_sel_ff   <= 1'b0;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gw_ff        <= gw_in;
         p32_ff       <= p32_in;
         p16_ff       <= p16_in;
         p8_ff        <= p8_in;
         left32_ff    <= left32_in;
         left16_ff    <= left16_in;
         left8_ff     <= left8_in;
         mul_sel_ff   <= mul_sel_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      seed_ff      <= seed_in;
      acc_ff       <= acc_in;
      mop_ff       <= mop_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ===== src/xrs_mul_unit.sv =====
// shared 32 by 32 multiplier with a registered product
module xrs_mul_unit (
   input  logic                clock,
   input  xrs_pkg::mul_req_type mul_req,
   output logic [63:0]         mul_prod
);
   import xrs_pkg::*;

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   // full product of the two operands
   assign prod_in = 64'(mul_req.a) * 64'(mul_req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

// ===== src/xrs_checker.sv =====
// port-level checks for the xoshiro random source, bound to the top level
module xrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [3:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value
);
   import xrs_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result changed");

   // not ready in the cycle after taking a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after a request");

   // a write taken with a free slot gives a valid zero result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_WRITE) && (!rsp_valid || rsp_ready)
      |-> ##2 rsp_valid && (rsp_value == 64'd0))
      else $error("write result missing or not zero");

   // no result straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind xoshiro_random_source_core xrs_checker u_xrs_checker (.*);
